/* rtl/core/mtxq_pkg.sv */
// Package for the mutex pool with FIFO wait queues.
// Holds sizes, field widths, status and action codes and the per-slot record type.
// No dependencies.
package mtxq_pkg;

    localparam int MAX_TASKS  = 16;
    localparam int POOL_SLOTS = 16;

    // Widths fixed by the word layout
    localparam int ACTION_W = 3;
    localparam int HANDLE_W = 5;
    localparam int CALLER_W = 5;
    localparam int STATUS_W = 3;
    localparam int WOKEN_W  = 4;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // Derived storage widths
    localparam int POS_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int SLOT_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int RING_AW    = SLOT_W + POS_W;
    localparam int RING_DEPTH = 1 << RING_AW;

    localparam logic [CALLER_W-1:0] MAIN_CTX = CALLER_W'(MAX_TASKS);
    localparam logic [CALLER_W-1:0] NO_OWNER = CALLER_W'(MAX_TASKS + 1);

    localparam logic [ACTION_W-1:0] ACT_CREATE  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DESTROY = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_LOCK    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_UNLOCK  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CANCEL  = 3'd4;

    localparam logic [STATUS_W-1:0] STS_OK            = 3'd0;
    localparam logic [STATUS_W-1:0] STS_INVALID_ARG   = 3'd1;
    localparam logic [STATUS_W-1:0] STS_TIMEOUT       = 3'd2;
    localparam logic [STATUS_W-1:0] STS_BUSY          = 3'd3;
    localparam logic [STATUS_W-1:0] STS_BLOCKED       = 3'd4;
    localparam logic [STATUS_W-1:0] STS_INVALID_STATE = 3'd5;
    localparam logic [STATUS_W-1:0] STS_PERMISSION    = 3'd6;
    localparam logic [STATUS_W-1:0] STS_NO_FREE_SLOT  = 3'd7;

    // Per-slot record kept in the slot memory
    typedef struct packed {
        logic [CALLER_W-1:0] owner;
        logic [POS_W-1:0]    head;
        logic [POS_W-1:0]    tail;
        logic [CNT_W-1:0]    count;
    } meta_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_META = 5'b00010,
        S_RING = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    // Ring position plus offset, wrapped at MAX_TASKS (offset never exceeds MAX_TASKS)
    function automatic logic [POS_W-1:0] ring_add(input logic [POS_W-1:0] pos,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(pos) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(MAX_TASKS)) begin
            sum = sum - (CNT_W + 1)'(MAX_TASKS);
        end
        return sum[POS_W-1:0];
    endfunction

endpackage

/* rtl/core/mutex_unit_with_fifo_waiters_core.sv */
// Mutex pool with FIFO wait queues: top level and whole datapath.
// Depends on mtxq_pkg for sizes, codes and the slot record type.
//
// Each input word is one request (create, destroy, lock, unlock, cancel_wait)
// and gives exactly one result word. Requests are handled one at a time by a
// small sequencer around two synchronous memories: a slot memory (owner, ring
// head, tail and count per mutex) and a waiter memory holding every mutex's
// ring of task ids. Create, destroy and lock pass through S_META to S_DONE;
// an unlock that hands the mutex to a waiter also passes through S_RING,
// since the oldest waiter needs a second memory read. Cancel_wait walks the
// waiter ring one entry per cycle in S_SCAN. A finished result sits in the
// output register while the next word is accepted; the sequencer stalls only
// when a second result is ready before the first is taken. After reset the
// pool is empty and no clearing pass is needed: slot records are rewritten
// by create.
module mutex_unit_with_fifo_waiters_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [2:0] action, [7:3] handle, [12:8] caller, [15:13] zero
    input  logic [mtxq_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [2:0] status, [7:3] new_handle, [8] woken_valid, [12:9] woken_task, [15:13] zero
    output logic [mtxq_pkg::M_TDATA_W-1:0]   m_tdata
);
    import mtxq_pkg::*;

    state_t state_reg, state_next;

    logic [ACTION_W-1:0] action_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [CALLER_W-1:0] caller_reg;

    logic [POOL_SLOTS-1:0] slot_used_reg, slot_used_next;

    meta_t meta_mem [POOL_SLOTS];
    meta_t meta_rd_reg;
    logic [SLOT_W-1:0] meta_raddr;
    logic              meta_we;
    logic [SLOT_W-1:0] meta_waddr;
    meta_t             meta_wdata;

    logic [POS_W-1:0]   ring_mem [RING_DEPTH];
    logic [POS_W-1:0]   ring_rd_reg;
    logic [RING_AW-1:0] ring_raddr;
    logic               ring_we;
    logic [RING_AW-1:0] ring_waddr;
    logic [POS_W-1:0]   ring_wdata;

    logic [POS_W-1:0] scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0] kept_reg, kept_next;

    logic                res_load;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [HANDLE_W-1:0] res_handle_reg, res_handle_next;
    logic                res_wv_reg, res_wv_next;
    logic [WOKEN_W-1:0]  res_wt_reg, res_wt_next;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 out_load;

    // Input word fields
    logic [HANDLE_W-1:0] s_handle;
    logic [HANDLE_W-1:0] s_handle_m1;
    logic [HANDLE_W-1:0] handle_m1;
    logic [SLOT_W-1:0]   slot_idx;
    logic                handle_ok;
    logic                slot_valid;
    logic                caller_ok;

    logic                free_found;
    logic [SLOT_W-1:0]   free_idx;

    meta_t               m;
    logic                keep;
    logic [CNT_W-1:0]    kept_new;

    assign s_handle    = s_tdata[7:3];
    assign s_handle_m1 = s_handle - HANDLE_W'(1);
    assign handle_m1   = handle_reg - HANDLE_W'(1);
    assign slot_idx    = handle_m1[SLOT_W-1:0];
    assign handle_ok   = (handle_reg != '0) && (handle_reg <= HANDLE_W'(POOL_SLOTS));
    assign slot_valid  = handle_ok && slot_used_reg[slot_idx];
    assign caller_ok   = caller_reg <= CALLER_W'(MAX_TASKS);
    assign m           = meta_rd_reg;
    assign meta_raddr  = s_handle_m1[SLOT_W-1:0];

    assign keep     = CALLER_W'(ring_rd_reg) != caller_reg;
    assign kept_new = kept_reg + CNT_W'(keep);

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    // Lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
            if (!slot_used_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        slot_used_next  = slot_used_reg;
        meta_we         = 1'b0;
        meta_waddr      = slot_idx;
        meta_wdata      = m;
        ring_we         = 1'b0;
        ring_waddr      = {slot_idx, m.tail};
        ring_wdata      = caller_reg[POS_W-1:0];
        ring_raddr      = {slot_idx, m.head};
        scan_idx_next   = scan_idx_reg;
        kept_next       = kept_reg;
        res_load        = 1'b0;
        res_status_next = STS_INVALID_ARG;
        res_handle_next = '0;
        res_wv_next     = 1'b0;
        res_wt_next     = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_META;
                end
            end

            S_META: begin
                res_load   = 1'b1;
                state_next = S_DONE;
                case (action_reg)
                    ACT_CREATE: begin
                        if (free_found) begin
                            slot_used_next[free_idx] = 1'b1;
                            meta_we          = 1'b1;
                            meta_waddr       = free_idx;
                            meta_wdata.owner = NO_OWNER;
                            meta_wdata.head  = '0;
                            meta_wdata.tail  = '0;
                            meta_wdata.count = '0;
                            res_status_next  = STS_OK;
                            res_handle_next  = HANDLE_W'(free_idx) + HANDLE_W'(1);
                        end else begin
                            res_status_next = STS_NO_FREE_SLOT;
                        end
                    end
                    ACT_DESTROY: begin
                        if (slot_valid) begin
                            if (m.owner != NO_OWNER || m.count != '0) begin
                                res_status_next = STS_INVALID_STATE;
                            end else begin
                                slot_used_next[slot_idx] = 1'b0;
                                res_status_next = STS_OK;
                            end
                        end
                    end
                    ACT_LOCK: begin
                        if (slot_valid && caller_ok) begin
                            if (m.owner == NO_OWNER) begin
                                meta_we          = 1'b1;
                                meta_wdata.owner = caller_reg;
                                res_status_next  = STS_OK;
                            end else if (caller_reg == MAIN_CTX) begin
                                res_status_next = STS_TIMEOUT;
                            end else if (m.owner == caller_reg) begin
                                res_status_next = STS_BUSY;
                            end else begin
                                // queue at tail unless the ring is full
                                if (m.count < CNT_W'(MAX_TASKS)) begin
                                    ring_we          = 1'b1;
                                    meta_we          = 1'b1;
                                    meta_wdata.tail  = ring_add(m.tail, CNT_W'(1));
                                    meta_wdata.count = m.count + CNT_W'(1);
                                end
                                res_status_next = STS_BLOCKED;
                            end
                        end
                    end
                    ACT_UNLOCK: begin
                        if (slot_valid && caller_ok) begin
                            if (m.owner == NO_OWNER) begin
                                res_status_next = STS_INVALID_STATE;
                            end else if (m.owner != caller_reg) begin
                                res_status_next = STS_PERMISSION;
                            end else if (m.count != '0) begin
                                // fetch oldest waiter, finish in S_RING
                                res_load   = 1'b0;
                                state_next = S_RING;
                            end else begin
                                meta_we          = 1'b1;
                                meta_wdata.owner = NO_OWNER;
                                res_status_next  = STS_OK;
                            end
                        end
                    end
                    ACT_CANCEL: begin
                        if (slot_valid && caller_ok) begin
                            res_status_next = STS_TIMEOUT;
                            if (m.count != '0) begin
                                res_load      = 1'b0;
                                scan_idx_next = '0;
                                kept_next     = '0;
                                state_next    = S_SCAN;
                            end
                        end
                    end
                    default: begin
                        res_status_next = STS_INVALID_ARG;
                    end
                endcase
            end

            S_RING: begin
                meta_we          = 1'b1;
                meta_wdata.owner = CALLER_W'(ring_rd_reg);
                meta_wdata.head  = ring_add(m.head, CNT_W'(1));
                meta_wdata.count = m.count - CNT_W'(1);
                res_load         = 1'b1;
                res_status_next  = STS_OK;
                res_wv_next      = 1'b1;
                res_wt_next      = WOKEN_W'(ring_rd_reg);
                state_next       = S_DONE;
            end

            S_SCAN: begin
                // compact: write each surviving entry back at head + kept
                if (keep) begin
                    ring_we    = 1'b1;
                    ring_waddr = {slot_idx, ring_add(m.head, kept_reg)};
                    ring_wdata = ring_rd_reg;
                end
                kept_next = kept_new;
                if (CNT_W'(scan_idx_reg) == m.count - CNT_W'(1)) begin
                    meta_we          = 1'b1;
                    meta_wdata.tail  = ring_add(m.head, kept_new);
                    meta_wdata.count = kept_new;
                    res_load         = 1'b1;
                    res_status_next  = STS_TIMEOUT;
                    state_next       = S_DONE;
                end else begin
                    ring_raddr    = {slot_idx,
                                     ring_add(m.head, CNT_W'(scan_idx_reg) + CNT_W'(1))};
                    scan_idx_next = scan_idx_reg + POS_W'(1);
                end
            end

            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            slot_used_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            slot_used_reg <= slot_used_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Request, scan and result payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            action_reg <= s_tdata[2:0];
            handle_reg <= s_handle;
            caller_reg <= s_tdata[12:8];
        end
        scan_idx_reg <= scan_idx_next;
        kept_reg     <= kept_next;
        if (res_load) begin
            res_status_reg <= res_status_next;
            res_handle_reg <= res_handle_next;
            res_wv_reg     <= res_wv_next;
            res_wt_reg     <= res_wt_next;
        end
        if (out_load) begin
            m_tdata_reg <= M_TDATA_W'({res_wt_reg, res_wv_reg, res_handle_reg, res_status_reg});
        end
    end

    // Slot memory: read in every idle cycle, so the record of the taken word holds for the whole request
    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        if (state_reg == S_IDLE) begin
            meta_rd_reg <= meta_mem[meta_raddr];
        end
    end

    // Waiter memory; during a scan the write address always trails the read address
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        ring_rd_reg <= ring_mem[ring_raddr];
    end

    a_used_one_change: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(slot_used_reg ^ $past(slot_used_reg)) <= 1)
        else $error("more than one slot changed use in a cycle");

    a_woken_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[8]) |-> (m_tdata[2:0] == STS_OK))
        else $error("woken task reported without ok status");

    a_kept_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (kept_reg <= CNT_W'(scan_idx_reg)))
        else $error("kept entries exceed scanned entries");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        meta_we |-> (meta_wdata.count <= CNT_W'(MAX_TASKS)))
        else $error("ring count written above capacity");

    a_write_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (meta_we || ring_we) |-> (state_reg != S_IDLE && state_reg != S_DONE))
        else $error("memory write outside request processing");

endmodule
